// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
// Both sample on the rising edge of clk and hold off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define PBR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// The expression must never be true.
`define PBR_NEVER(lbl, expr, msg) \
    `PBR_ASSERT(lbl, !(expr), msg)

`endif

// File: hw/rtl/pbr_pkg.sv
`default_nettype none
// ============================================================================
// pbr_pkg
// Types and constants shared by the bridge parent resolver modules.
// ============================================================================
package pbr_pkg;

    // Default table capacity
    localparam int MAX_RECORDS_DEF = 64;

    // Class code of a PCI-to-PCI bridge
    localparam logic [7:0] CLASS_BRIDGE   = 8'h06;
    localparam logic [7:0] SUBCLASS_P2P   = 8'h04;

    // Width of the parent position field
    localparam int PP_W = 6;

    // Input word: one function record
    typedef struct packed {
        logic [15:0] segment;
        logic [7:0]  bus;
        logic [4:0]  device_number;
        logic [2:0]  function_number;
        logic [7:0]  base_class;
        logic [7:0]  sub_class;
        logic [7:0]  secondary_bus;
        logic [7:0]  subordinate_bus;
        logic        final_record;
    } rec_word_t;

    // Output word: one resolved record
    typedef struct packed {
        logic [15:0]     out_segment;
        logic [7:0]      out_bus;
        logic [4:0]      out_device;
        logic [2:0]      out_function;
        logic            is_bridge;
        logic            has_parent;
        logic [PP_W-1:0] parent_position;
        logic            overflow;
        logic            last_result;
    } res_word_t;

    // Table entry; the first four fields form the sort key
    typedef struct packed {
        logic [15:0] segment;
        logic [7:0]  bus;
        logic [4:0]  device;
        logic [2:0]  func;
        logic        bridge;
        logic [7:0]  sec;
        logic [7:0]  sub;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture incoming word
        logic ins_read;    // read entry below insertion point
        logic shift;       // move read entry up one slot
        logic put;         // write new entry at insertion point
        logic child_read;  // read current child entry
        logic child_load;  // latch child, start bridge scan
        logic scan_step;   // evaluate one candidate bridge
        logic emit;        // load result register
        logic next_child;  // advance child index
        logic end_load;    // clear table count and flags
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic final_rec;
        logic pos_zero;
        logic pos_one;
        logic key_less;
        logic scan_last;
        logic child_last;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/pci_bridge_parent_resolver.sv
`default_nettype none
// ============================================================================
// pci_bridge_parent_resolver
// Sorts PCI function records and finds each one's narrowest enclosing bridge.
// ============================================================================
// Usage:
//   rec channel (rec_valid/rec_stall/rec_data) takes one function record per
//   word. Each record is insertion-sorted into a table by segment, bus,
//   device and function, with larger entries shifted up through the table
//   RAM one entry per cycle. Records past capacity are dropped and flagged
//   in every result of that load.
//   A word with final_record set closes the load. For each held record the
//   block scans all n entries through the single RAM read port.
//   res channel (res_valid/res_stall/res_data) gives one word per held
//   record in sorted order, last_result on the final one. A stalled result
//   holds in the output register; the scan of the next record goes on and
//   waits only to load its own result.
//   rec_stall is high from each accepted record until it is placed or, for
//   a final one, until the last result is loaded. Reset empties the table
//   and clears the overflow flag; the block then takes records at once.
// ============================================================================
module pci_bridge_parent_resolver #(
    parameter int MAX_RECORDS = pbr_pkg::MAX_RECORDS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rec_valid,
    output logic                    rec_stall,
    input  wire pbr_pkg::rec_word_t rec_data,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output pbr_pkg::res_word_t      res_data
);
    import pbr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    pbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table, scan and result datapath
    pbr_datapath #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_data  (rec_data),
        .cmd       (cmd),
        .stat      (stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
`default_nettype wire

// File: hw/rtl/pbr_ram.sv
`default_nettype none
// ============================================================================
// pbr_ram
// Simple dual port RAM: one write port, one read port with registered data.
// ============================================================================
module pbr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pbr_datapath.sv
`default_nettype none
// ============================================================================
// pbr_datapath
// Record table, insertion pointer, child/bridge scan and result register.
// ============================================================================
module pbr_datapath #(
    parameter int MAX_RECORDS = pbr_pkg::MAX_RECORDS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pbr_pkg::rec_word_t rec_data,
    input  wire pbr_pkg::dp_cmd_t  cmd,
    output pbr_pkg::dp_stat_t      stat,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output pbr_pkg::res_word_t     res_data
);
    import pbr_pkg::*;

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    // Control registers
    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic [AW-1:0] child_idx_reg;
    logic          res_valid_reg;

    // Payload registers
    entry_t        new_rec_reg;
    logic          final_reg;
    logic [AW-1:0] pos_reg;
    entry_t        child_reg;
    logic [AW-1:0] eval_idx_reg;
    logic          found_reg;
    logic [AW-1:0] best_idx_reg;
    logic [7:0]    best_span_reg;
    res_word_t     res_reg;

    // RAM ports
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [ENTRY_W-1:0]     rd_raw;
    entry_t                 rd_ent;

    // Incoming record and candidate evaluation
    entry_t     in_ent;
    logic       in_bridge;
    logic       hit;
    logic [7:0] span;

    assign rd_ent = entry_t'(rd_raw);

    // Record table
    pbr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RECORDS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    // Decode incoming word; non-bridges keep a zero bus range
    always_comb
    begin
        in_bridge      = (rec_data.base_class == CLASS_BRIDGE) &&
                         (rec_data.sub_class == SUBCLASS_P2P);
        in_ent.segment = rec_data.segment;
        in_ent.bus     = rec_data.bus;
        in_ent.device  = rec_data.device_number;
        in_ent.func    = rec_data.function_number;
        in_ent.bridge  = in_bridge;
        in_ent.sec     = in_bridge ? rec_data.secondary_bus : 8'h00;
        in_ent.sub     = in_bridge ? rec_data.subordinate_bus : 8'h00;
    end

    // Table write: shifted entry or new entry at the insertion point
    assign wr_en   = cmd.shift | cmd.put;
    assign wr_addr = pos_reg;
    assign wr_data = cmd.shift ? rd_raw : ENTRY_W'(new_rec_reg);

    // Table read address
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.ins_read)
        begin
            rd_en   = 1'b1;
            rd_addr = pos_reg - AW'(1);
        end
        else if (cmd.shift)
        begin
            rd_en   = !stat.pos_one;
            rd_addr = pos_reg - AW'(2);
        end
        else if (cmd.child_read)
        begin
            rd_en   = 1'b1;
            rd_addr = child_idx_reg;
        end
        else if (cmd.child_load)
        begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
        else if (cmd.scan_step)
        begin
            rd_en   = !stat.scan_last;
            rd_addr = eval_idx_reg + AW'(1);
        end
    end

    // Candidate bridge test against the current child
    always_comb
    begin
        span = rd_ent.sub - rd_ent.sec;
        hit  = (eval_idx_reg != child_idx_reg) && rd_ent.bridge &&
               (rd_ent.segment == child_reg.segment) &&
               (rd_ent.sec <= rd_ent.sub) &&
               (child_reg.bus >= rd_ent.sec) && (child_reg.bus <= rd_ent.sub);
    end

    // Status
    always_comb
    begin
        stat.full       = (count_reg == CW'(MAX_RECORDS));
        stat.final_rec  = final_reg;
        stat.pos_zero   = (pos_reg == '0);
        stat.pos_one    = (pos_reg == AW'(1));
        stat.key_less   = {new_rec_reg.segment, new_rec_reg.bus,
                           new_rec_reg.device, new_rec_reg.func} <
                          {rd_ent.segment, rd_ent.bus, rd_ent.device, rd_ent.func};
        stat.scan_last  = (CW'(eval_idx_reg) + CW'(1)) == count_reg;
        stat.child_last = (CW'(child_idx_reg) + CW'(1)) == count_reg;
        stat.out_free   = !res_valid_reg || !res_stall;
    end

    // Count, overflow flag, child index, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            child_idx_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && stat.full)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.put)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.next_child)
            begin
                child_idx_reg <= child_idx_reg + AW'(1);
            end
            if (cmd.end_load)
            begin
                count_reg     <= '0;
                ovf_reg       <= 1'b0;
                child_idx_reg <= '0;
            end
            if (cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Insertion and scan payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            new_rec_reg <= in_ent;
            final_reg   <= rec_data.final_record;
            pos_reg     <= count_reg[AW-1:0];
        end
        if (cmd.shift)
        begin
            pos_reg <= pos_reg - AW'(1);
        end
        if (cmd.child_load)
        begin
            child_reg     <= rd_ent;
            eval_idx_reg  <= '0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_span_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            eval_idx_reg <= eval_idx_reg + AW'(1);
            if (hit && (!found_reg || (span < best_span_reg)))
            begin
                found_reg     <= 1'b1;
                best_idx_reg  <= eval_idx_reg;
                best_span_reg <= span;
            end
        end
        if (cmd.emit)
        begin
            res_reg.out_segment     <= child_reg.segment;
            res_reg.out_bus         <= child_reg.bus;
            res_reg.out_device      <= child_reg.device;
            res_reg.out_function    <= child_reg.func;
            res_reg.is_bridge       <= child_reg.bridge;
            res_reg.has_parent      <= found_reg;
            res_reg.parent_position <= found_reg ? PP_W'(best_idx_reg) : '0;
            res_reg.overflow        <= ovf_reg;
            res_reg.last_result     <= stat.child_last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule
`default_nettype wire

// File: hw/rtl/pbr_ctrl.sv
`default_nettype none
// ============================================================================
// pbr_ctrl
// Sequencer for sorted insertion, per-record parent scan and result output.
// ============================================================================
module pbr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rec_valid,
    output logic                   rec_stall,
    input  wire pbr_pkg::dp_stat_t stat,
    output pbr_pkg::dp_cmd_t       cmd
);
    import pbr_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_START = 3'd1;
    localparam logic [2:0] S_INS_CMP   = 3'd2;
    localparam logic [2:0] S_INS_PUT   = 3'd3;
    localparam logic [2:0] S_RD_CHILD  = 3'd4;
    localparam logic [2:0] S_LD_CHILD  = 3'd5;
    localparam logic [2:0] S_SCAN      = 3'd6;
    localparam logic [2:0] S_EMIT      = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] after_ins;

    // Where to go once a record is placed or dropped
    assign after_ins = stat.final_rec ? S_RD_CHILD : S_IDLE;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (rec_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_INS_START;
                end
            end
            S_INS_START:
            begin
                if (stat.full)
                begin
                    state_next = after_ins;
                end
                else if (stat.pos_zero)
                begin
                    cmd.put    = 1'b1;
                    state_next = after_ins;
                end
                else
                begin
                    cmd.ins_read = 1'b1;
                    state_next   = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (stat.key_less)
                begin
                    cmd.shift  = 1'b1;
                    state_next = stat.pos_one ? S_INS_PUT : S_INS_CMP;
                end
                else
                begin
                    cmd.put    = 1'b1;
                    state_next = after_ins;
                end
            end
            S_INS_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = after_ins;
            end
            S_RD_CHILD:
            begin
                cmd.child_read = 1'b1;
                state_next     = S_LD_CHILD;
            end
            S_LD_CHILD:
            begin
                cmd.child_load = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.child_last)
                    begin
                        cmd.end_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_child = 1'b1;
                        state_next     = S_RD_CHILD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign rec_stall = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// File: hw/rtl/pbr_checker.sv
`default_nettype none
`include "assert_macros.svh"
// ============================================================================
// pbr_checker
// Port-level checks on the bridge parent resolver, bound to the top level.
// ============================================================================
module pbr_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rec_valid,
    input  wire logic               rec_stall,
    input  wire pbr_pkg::rec_word_t rec_data,
    input  wire logic               res_valid,
    input  wire logic               res_stall,
    input  wire pbr_pkg::res_word_t res_data
);
    import pbr_pkg::*;

    // A stalled result word holds
    `PBR_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res_data), "result word changed under stall")

    // Records are not taken while an output run is still going
    `PBR_NEVER(a_no_rec_mid_run, res_valid && !res_data.last_result && !rec_stall, "record accepted during output run")

    // Root records report position zero
    `PBR_NEVER(a_root_pos, res_valid && !res_data.has_parent && (res_data.parent_position != '0), "root with nonzero parent position")

    // Accepting a record always raises rec_stall
    `PBR_ASSERT(a_busy_after_rec, rec_valid && !rec_stall |=> rec_stall, "no busy cycle after record")

    // A stalled record word holds
    `PBR_ASSERT(a_rec_hold, rec_valid && rec_stall |=> rec_valid && $stable(rec_data), "record word changed under stall")

endmodule

bind pci_bridge_parent_resolver pbr_checker u_pbr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec_data  (rec_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);
`default_nettype wire

// File: tb/pci_bridge_parent_resolver_tb.sv
`default_nettype none
// ============================================================================
// pci_bridge_parent_resolver_tb
// Self-checking bench for the bridge parent resolver. Function records are
// sent as loads, each closed by a final_record word. A local table mirrors
// the sorted record store. When a load closes, the bench resolves every
// record's narrowest enclosing bridge and queues the result words that the
// block should emit. The directed loads cover field extremes, self exclusion,
// span ties, inverted ranges, non-bridge class codes, duplicate keys and
// segment separation. Random loads follow: small bus trees, plus one load
// that exactly fills the table and one that overflows it.
// ============================================================================
module pci_bridge_parent_resolver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbr_pkg::*;

    localparam int CAPACITY     = MAX_RECORDS_DEF;
    localparam int TARGET_WORDS = 450;
    localparam int REPORT_LIMIT = 10;

    // One held record, key = {segment, bus, device, function}
    typedef struct {
        logic [31:0] key;
        logic        bridge;
        logic [7:0]  sec;
        logic [7:0]  sub;
    } held_rec_t;

    // Record word waiting to be sent; drain_first holds it back until the
    // block has returned every result it owes
    typedef struct {
        rec_word_t word;
        bit        drain_first;
    } outgoing_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      rec_valid = 1'b0;
    logic      rec_stall;
    rec_word_t rec_data  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_word_t res_data;

    // Mirror of the sorted record table
    held_rec_t held_recs [CAPACITY];
    int        held_count    = 0;
    bit        held_overflow = 1'b0;

    res_word_t expected_results [$];
    outgoing_t outgoing_recs [$];
    res_word_t oldest_result;
    int        queued_words = 0;
    int        mismatches   = 0;
    int        results_seen = 0;

    // Sender and receiver pacing
    int send_gap  = 0;
    int send_calm = 0;
    int rcv_gap   = 0;
    int rcv_calm  = 0;
    int stall_len = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    pci_bridge_parent_resolver #(
        .MAX_RECORDS(CAPACITY)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec_data  (rec_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #2 clk = ~clk;

    // Find each held record's parent and queue the result words
    function automatic void resolve_parents();
        res_word_t res;
        bit        found;
        int        best;
        int        best_span;
        int        span;
        for (int c = 0; c < held_count; c++)
        begin
            found     = 1'b0;
            best      = 0;
            best_span = 0;
            for (int b = 0; b < held_count; b++)
            begin
                if (b != c && held_recs[b].bridge
                    && held_recs[b].key[31:16] == held_recs[c].key[31:16]
                    && held_recs[b].sec <= held_recs[b].sub
                    && held_recs[c].key[15:8] >= held_recs[b].sec
                    && held_recs[c].key[15:8] <= held_recs[b].sub)
                begin
                    span = int'(held_recs[b].sub) - int'(held_recs[b].sec);
                    // strict compare keeps the first bridge on equal spans
                    if (!found || span < best_span)
                    begin
                        found     = 1'b1;
                        best      = b;
                        best_span = span;
                    end
                end
            end
            res.out_segment     = held_recs[c].key[31:16];
            res.out_bus         = held_recs[c].key[15:8];
            res.out_device      = held_recs[c].key[7:3];
            res.out_function    = held_recs[c].key[2:0];
            res.is_bridge       = held_recs[c].bridge;
            res.has_parent      = found;
            res.parent_position = found ? PP_W'(best) : '0;
            res.overflow        = held_overflow;
            res.last_result     = (c == held_count - 1);
            expected_results.push_back(res);
        end
        held_count    = 0;
        held_overflow = 1'b0;
    endfunction

    // Stable insertion of one accepted word; a final word triggers resolution
    function automatic void place_record(rec_word_t w);
        held_rec_t r;
        int        pos;
        r.key    = {w.segment, w.bus, w.device_number, w.function_number};
        r.bridge = (w.base_class == CLASS_BRIDGE) && (w.sub_class == SUBCLASS_P2P);
        r.sec    = r.bridge ? w.secondary_bus : 8'h00;
        r.sub    = r.bridge ? w.subordinate_bus : 8'h00;
        if (held_count < CAPACITY)
        begin
            pos = held_count;
            while (pos > 0 && r.key < held_recs[pos - 1].key)
            begin
                held_recs[pos] = held_recs[pos - 1];
                pos--;
            end
            held_recs[pos] = r;
            held_count++;
        end
        else
        begin
            held_overflow = 1'b1;
        end
        if (w.final_record)
            resolve_parents();
    endfunction

    function automatic void queue_record(logic [15:0] seg, logic [7:0] bus,
                                         logic [4:0] dev, logic [2:0] fn,
                                         logic [7:0] bc, logic [7:0] sc,
                                         logic [7:0] sec, logic [7:0] subb,
                                         bit fin, bit drain = 1'b0);
        outgoing_t o;
        o.word.segment         = seg;
        o.word.bus             = bus;
        o.word.device_number   = dev;
        o.word.function_number = fn;
        o.word.base_class      = bc;
        o.word.sub_class       = sc;
        o.word.secondary_bus   = sec;
        o.word.subordinate_bus = subb;
        o.word.final_record    = fin;
        o.drain_first          = drain;
        outgoing_recs.push_back(o);
        queued_words++;
    endfunction

    // One random load: mostly a bus tree inside a 16-bus window of one
    // segment, with some stray segments, stray buses and repeated keys
    function automatic void queue_bus_tree(int n, bit drain);
        rec_word_t   made [$];
        rec_word_t   dup;
        logic [15:0] home_seg;
        logic [15:0] seg;
        logic [7:0]  win;
        logic [7:0]  bus;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  tmp;
        logic [7:0]  bc;
        logic [7:0]  sc;
        logic [4:0]  dev;
        logic [2:0]  fn;
        int          roll;
        case ($urandom_range(0, 3))
            0, 1: home_seg = 16'h0000;
            2:    home_seg = 16'($urandom);
            default: home_seg = 16'($urandom_range(0, 3));
        endcase
        win = 8'($urandom_range(0, 240));
        for (int i = 0; i < n; i++)
        begin
            if (made.size() != 0 && $urandom_range(0, 99) < 12)
            begin
                dup = made[$urandom_range(0, made.size() - 1)];
                seg = dup.segment;
                bus = dup.bus;
                dev = dup.device_number;
                fn  = dup.function_number;
            end
            else
            begin
                seg = ($urandom_range(0, 99) < 85) ? home_seg : 16'($urandom);
                bus = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                   : win + 8'($urandom_range(0, 15));
                dev = 5'($urandom);
                fn  = 3'($urandom);
            end
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                bc = CLASS_BRIDGE;
                sc = SUBCLASS_P2P;
            end
            else if (roll < 48)
            begin
                bc = CLASS_BRIDGE;
                sc = 8'($urandom);
            end
            else if (roll < 56)
            begin
                bc = 8'($urandom);
                sc = SUBCLASS_P2P;
            end
            else
            begin
                bc = 8'($urandom);
                sc = 8'($urandom);
            end
            lo   = win + 8'($urandom_range(0, 15));
            hi   = lo + 8'($urandom_range(0, 8));
            roll = $urandom_range(0, 99);
            if (roll < 12)
            begin
                // inverted range
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            else if (roll < 18)
            begin
                lo = 8'($urandom);
                hi = 8'($urandom);
            end
            queue_record(seg, bus, dev, fn, bc, sc, lo, hi, i == n - 1, drain && i == 0);
            made.push_back(outgoing_recs[outgoing_recs.size() - 1].word);
        end
    endfunction

    // Gap length: mostly none or short, a few long, with calm stretches
    function automatic int draw_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic string describe(res_word_t w);
        return $sformatf("seg=%h bus=%h dev=%h fn=%h br=%b par=%b pos=%0d ovf=%b last=%b",
                         w.out_segment, w.out_bus, w.out_device, w.out_function,
                         w.is_bridge, w.has_parent, w.parent_position, w.overflow,
                         w.last_result);
    endfunction

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s", $time, what);
    endfunction

    // Record driver: predicts on every accepted word, then loads the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid <= 1'b0;
            rec_data  <= '0;
        end
        else
        begin
            if (rec_valid && !rec_stall)
                place_record(rec_data);
            if (!rec_valid || !rec_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    rec_valid <= 1'b0;
                end
                else if (outgoing_recs.size() != 0
                         && !(outgoing_recs[0].drain_first && expected_results.size() != 0))
                begin
                    rec_data  <= outgoing_recs[0].word;
                    rec_valid <= 1'b1;
                    void'(outgoing_recs.pop_front());
                    send_gap = draw_gap(send_calm);
                end
                else
                begin
                    rec_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall: random gaps plus one long hold-off in the middle of a run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= 40 && res_valid)
        begin
            hold_done = 1'b1;
            hold_left = 300;
            res_stall <= 1'b1;
        end
        else if (rcv_gap > 0)
        begin
            rcv_gap--;
            res_stall <= 1'b1;
        end
        else
        begin
            stall_len = draw_gap(rcv_calm);
            rcv_gap   = (stall_len != 0) ? stall_len - 1 : 0;
            res_stall <= (stall_len != 0);
        end
    end

    // Result monitor: compare against the oldest expected word
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                flag_mismatch({"unexpected result word: ", describe(res_data)});
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (res_data.out_segment     !== oldest_result.out_segment
                    || res_data.out_bus         !== oldest_result.out_bus
                    || res_data.out_device      !== oldest_result.out_device
                    || res_data.out_function    !== oldest_result.out_function
                    || res_data.is_bridge       !== oldest_result.is_bridge
                    || res_data.has_parent      !== oldest_result.has_parent
                    || res_data.parent_position !== oldest_result.parent_position
                    || res_data.overflow        !== oldest_result.overflow
                    || res_data.last_result     !== oldest_result.last_result)
                begin
                    flag_mismatch({"result mismatch: expected ", describe(oldest_result),
                                   " got ", describe(res_data)});
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int loads;

        // lone all-zero record: a root
        queue_record(16'h0000, 8'h00, 5'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);

        // all-ones key, non-bridge with bridge bus fields set (ignored)
        queue_record(16'hFFFF, 8'hFF, 5'd31, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
        // wide bridge whose own bus lies in its range: never its own parent
        queue_record(16'h0001, 8'd10, 5'd3, 3'd0, CLASS_BRIDGE, SUBCLASS_P2P,
                     8'd10, 8'd20, 1'b0);
        // narrower bridge 12..14 and a child on bus 13
        queue_record(16'h0001, 8'd12, 5'd0, 3'd0, CLASS_BRIDGE, SUBCLASS_P2P,
                     8'd12, 8'd14, 1'b0);
        queue_record(16'h0001, 8'd13, 5'd5, 3'd1, 8'h01, 8'h06, 8'h00, 8'h00, 1'b0);
        // equal spans: the lower sorted bridge wins for the bus 16 child
        queue_record(16'h0001, 8'd20, 5'd0, 3'd0, CLASS_BRIDGE, SUBCLASS_P2P,
                     8'd15, 8'd17, 1'b0);
        queue_record(16'h0001, 8'd5, 5'd0, 3'd0, CLASS_BRIDGE, SUBCLASS_P2P,
                     8'd16, 8'd18, 1'b0);
        queue_record(16'h0001, 8'd16, 5'd2, 3'd0, 8'h02, 8'h00, 8'h00, 8'h00, 1'b0);
        // inverted range is skipped; full-range bridge takes the bus 35 child
        queue_record(16'h0001, 8'd30, 5'd0, 3'd0, CLASS_BRIDGE, SUBCLASS_P2P,
                     8'd40, 8'd31, 1'b0);
        queue_record(16'h0001, 8'd2, 5'd0, 3'd0, CLASS_BRIDGE, SUBCLASS_P2P,
                     8'd0, 8'd255, 1'b0);
        queue_record(16'h0001, 8'd35, 5'd1, 3'd1, 8'h03, 8'h00, 8'h00, 8'h00, 1'b0);
        // near-miss class codes with tight ranges: not bridges
        queue_record(16'h0001, 8'd3, 5'd0, 3'd0, CLASS_BRIDGE, 8'h05, 8'd16, 8'd16, 1'b0);
        queue_record(16'h0001, 8'd4, 5'd0, 3'd0, 8'h07, SUBCLASS_P2P, 8'd13, 8'd13, 1'b0);
        // same key as the bus 13 child: sorts after it
        queue_record(16'h0001, 8'd13, 5'd5, 3'd1, CLASS_BRIDGE, SUBCLASS_P2P,
                     8'd50, 8'd60, 1'b0);
        // zero-span bridge in another segment serves only that segment
        queue_record(16'h0002, 8'd16, 5'd0, 3'd0, CLASS_BRIDGE, SUBCLASS_P2P,
                     8'd16, 8'd16, 1'b0);
        queue_record(16'h0002, 8'd16, 5'd1, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        // closing word is itself a bridge over the all-ones record
        queue_record(16'hFFFF, 8'h00, 5'd0, 3'd0, CLASS_BRIDGE, SUBCLASS_P2P,
                     8'h00, 8'hFF, 1'b1);

        // random loads, with one exactly full table and one overflow
        loads = 0;
        while (queued_words < TARGET_WORDS)
        begin
            if (loads == 8)
                queue_bus_tree(CAPACITY, 1'b1);
            else if (loads == 20)
                queue_bus_tree(CAPACITY + 6, 1'b0);
            else if ($urandom_range(0, 15) == 0)
                queue_bus_tree($urandom_range(13, 30), $urandom_range(0, 4) == 0);
            else
                queue_bus_tree($urandom_range(1, 12), $urandom_range(0, 4) == 0);
            loads++;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (outgoing_recs.size() != 0 || rec_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
